@@ sv/hcva_pkg.sv @@
// Package for the Hough circle vote accumulator: payload types, command
// codes, register indexes and the Q1.14 quarter-wave sine table.
// No dependencies.
package hcva_pkg;

  localparam logic [1:0] CMD_VOTE  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [2:0] REG_RADIUS_0   = 3'd0;
  localparam logic [2:0] REG_RADIUS_1   = 3'd1;
  localparam logic [2:0] REG_RADIUS_2   = 3'd2;
  localparam logic [2:0] REG_RADIUS_3   = 3'd3;
  localparam logic [2:0] REG_RADIUS_CNT = 3'd4;
  localparam logic [2:0] REG_ANGLE_STEP = 3'd5;
  localparam logic [2:0] REG_CELL_SHIFT = 3'd6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // Store address width for the largest grid: 4 levels of 1024 x 1024 cells
  localparam int CLR_ADDR_W = 22;

  typedef struct packed {
    logic [1:0] cmd;
    logic [9:0] pixel_x;
    logic [9:0] pixel_y;
    logic [7:0] edge_value;
    logic [1:0] read_level;
    logic [6:0] read_cell_x;
    logic [6:0] read_cell_y;
  } in_beat_t;

  typedef struct packed {
    logic [10:0] votes_cast;
    logic [15:0] cell_count;
  } out_beat_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;      // capture the input beat
    logic       clr_wr;    // write zero at clear address
    logic       vote_go;   // issue one vote probe for (level, angle)
    logic       rd_go;     // issue a cell read
    logic [1:0] level;
    logic [8:0] angle;
    logic [CLR_ADDR_W-1:0] clr_addr;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic busy;  // vote pipe or cell read still holds work
  } dp_sts_t;

  // Q1.14 sine, whole degrees 0..90
  function automatic logic [14:0] sine_q14(input logic [6:0] d);
    logic [14:0] v;
    case (d)
      7'd0: v=0; 7'd1: v=286; 7'd2: v=572; 7'd3: v=857; 7'd4: v=1143;
      7'd5: v=1428; 7'd6: v=1713; 7'd7: v=1997; 7'd8: v=2280; 7'd9: v=2563;
      7'd10: v=2845; 7'd11: v=3126; 7'd12: v=3406; 7'd13: v=3686; 7'd14: v=3964;
      7'd15: v=4240; 7'd16: v=4516; 7'd17: v=4790; 7'd18: v=5063; 7'd19: v=5334;
      7'd20: v=5604; 7'd21: v=5872; 7'd22: v=6138; 7'd23: v=6402; 7'd24: v=6664;
      7'd25: v=6924; 7'd26: v=7182; 7'd27: v=7438; 7'd28: v=7692; 7'd29: v=7943;
      7'd30: v=8192; 7'd31: v=8438; 7'd32: v=8682; 7'd33: v=8923; 7'd34: v=9162;
      7'd35: v=9397; 7'd36: v=9630; 7'd37: v=9860; 7'd38: v=10087; 7'd39: v=10311;
      7'd40: v=10531; 7'd41: v=10749; 7'd42: v=10963; 7'd43: v=11174;
      7'd44: v=11381; 7'd45: v=11585; 7'd46: v=11786; 7'd47: v=11982;
      7'd48: v=12176; 7'd49: v=12365; 7'd50: v=12551; 7'd51: v=12733;
      7'd52: v=12911; 7'd53: v=13085; 7'd54: v=13255; 7'd55: v=13421;
      7'd56: v=13583; 7'd57: v=13741; 7'd58: v=13894; 7'd59: v=14044;
      7'd60: v=14189; 7'd61: v=14330; 7'd62: v=14466; 7'd63: v=14598;
      7'd64: v=14726; 7'd65: v=14849; 7'd66: v=14968; 7'd67: v=15082;
      7'd68: v=15191; 7'd69: v=15296; 7'd70: v=15396; 7'd71: v=15491;
      7'd72: v=15582; 7'd73: v=15668; 7'd74: v=15749; 7'd75: v=15826;
      7'd76: v=15897; 7'd77: v=15964; 7'd78: v=16026; 7'd79: v=16083;
      7'd80: v=16135; 7'd81: v=16182; 7'd82: v=16225; 7'd83: v=16262;
      7'd84: v=16294; 7'd85: v=16322; 7'd86: v=16344; 7'd87: v=16362;
      7'd88: v=16374; 7'd89: v=16382; 7'd90: v=16384;
      default: v=0;
    endcase
    return v;
  endfunction

  // Signed Q1.14 sine of an angle in 0..449 degrees (wraps once)
  function automatic logic signed [15:0] sin_deg(input logic [8:0] d_in);
    logic [8:0] d;
    logic [14:0] m;
    logic neg;
    d = (d_in >= 9'd360) ? d_in - 9'd360 : d_in;
    neg = 1'b0;
    if (d <= 9'd90) m = sine_q14(d[6:0]);
    else if (d <= 9'd180) m = sine_q14(7'(9'd180 - d));
    else if (d <= 9'd270) begin
      m = sine_q14(7'(d - 9'd180)); neg = 1'b1;
    end else begin
      m = sine_q14(7'(9'd360 - d)); neg = 1'b1;
    end
    return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

endpackage

@@ sv/hcva_datapath.sv @@
// Datapath: captured item, vote pipeline (trig, multiply, center, store
// read-modify-write), cell read and vote counter. Uses hcva_pkg.
module hcva_datapath #(
  parameter int ACC_WIDTH     = 128,
  parameter int ACC_HEIGHT    = 128,
  parameter int RADIUS_LEVELS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  hcva_pkg::dp_cmd_t   cmd,
  input  hcva_pkg::in_beat_t  in_beat,
  input  logic [7:0]          radius [4],
  input  logic [1:0]          cell_shift,
  output hcva_pkg::dp_sts_t   sts,
  output logic [10:0]         votes,
  output logic [15:0]         cell_count
);
  localparam int XW = $clog2(ACC_WIDTH);
  localparam int YW = $clog2(ACC_HEIGHT);
  localparam int LW = (RADIUS_LEVELS > 1) ? $clog2(RADIUS_LEVELS) : 1;
  localparam int AW = LW + YW + XW;
  // Grid sides are rounded up to powers of two in the address
  localparam int DEPTH = RADIUS_LEVELS << (YW + XW);

  logic [15:0] store [DEPTH];

  hcva_pkg::in_beat_t item;

  // Stage 1: trig lookup and radius
  logic              s1_v;
  logic signed [15:0] s1_cos, s1_sin;
  logic [7:0]        s1_r;
  // Stage 2: products
  logic              s2_v;
  logic signed [24:0] s2_pc, s2_ps;
  // Stage 3: center cell and range check
  logic              s3_v;
  logic [AW-1:0]     s3_addr;
  // Stage 4: store read data valid
  logic              s4_v;
  logic [AW-1:0]     s4_addr;
  logic [15:0]       s4_q;
  logic              rd_v;
  logic              rd_ok;

  // Level index into store address (levels beyond storage are never voted)
  logic [LW-1:0] s1_lv, s2_lv;

  // Center from numerator, truncated toward zero
  function automatic logic signed [27:0] center(input logic [9:0] pix,
                                                input logic signed [24:0] prod,
                                                input logic [1:0] sh);
    logic signed [27:0] num;
    logic [27:0] mag;
    num = $signed({4'd0, pix, 14'd0}) - 28'(prod);
    mag = num[27] ? 28'(-num) : 28'(num);
    mag = (mag >> 14) >> sh;
    return num[27] ? -$signed(mag) : $signed(mag);
  endfunction

  logic signed [27:0] ca, cb;
  logic [10:0] gw, gh;
  always_comb begin
    ca = center(item.pixel_x, s2_pc, cell_shift);
    cb = center(item.pixel_y, s2_ps, cell_shift);
    gw = 11'(ACC_WIDTH >> cell_shift);
    gh = 11'(ACC_HEIGHT >> cell_shift);
  end

  // Capture item
  always_ff @(posedge clk) begin
    if (cmd.load) item <= in_beat;
  end

  // Vote pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0; s2_v <= 1'b0; s3_v <= 1'b0; s4_v <= 1'b0; rd_v <= 1'b0;
      votes <= '0;
    end else begin
      s1_v <= cmd.vote_go;
      s2_v <= s1_v;
      s3_v <= s2_v && !ca[27] && !cb[27] && (ca < 28'(gw)) && (cb < 28'(gh));
      s4_v <= s3_v;
      rd_v <= cmd.rd_go;
      if (cmd.load) votes <= '0;
      else if (s3_v) votes <= votes + 11'd1;
    end
  end

  always_ff @(posedge clk) begin
    s1_cos <= hcva_pkg::sin_deg(cmd.angle + 9'd90);
    s1_sin <= hcva_pkg::sin_deg(cmd.angle);
    s1_r   <= radius[cmd.level];
    s1_lv  <= LW'(cmd.level);
    s2_pc  <= $signed({1'b0, s1_r}) * s1_cos;
    s2_ps  <= $signed({1'b0, s1_r}) * s1_sin;
    s2_lv  <= s1_lv;
    s3_addr <= {s2_lv, YW'(cb), XW'(ca)};
    s4_addr <= s3_addr;
  end

  // Store: one read port, one write port. Read-after-write hazards on the
  // same cell are forwarded from the write stage.
  logic [15:0] s4_cur;
  logic        fwd;
  logic [15:0] fwd_val;
  logic [AW-1:0] rd_addr;
  always_comb begin
    rd_addr = cmd.rd_go ? {LW'(item.read_level), YW'(item.read_cell_y),
                           XW'(item.read_cell_x)} : s3_addr;
  end
  always_ff @(posedge clk) begin
    s4_q <= store[rd_addr];
    fwd <= s4_v && s3_v && (s4_addr == s3_addr);
    fwd_val <= (s4_cur == 16'hFFFF) ? s4_cur : s4_cur + 16'd1;
    if (cmd.clr_wr) store[cmd.clr_addr[AW-1:0]] <= '0;
    else if (s4_v) store[s4_addr] <= (s4_cur == 16'hFFFF) ? s4_cur : s4_cur + 16'd1;
  end
  assign s4_cur = fwd ? fwd_val : s4_q;

  // Read result
  always_comb begin
    rd_ok = (32'(item.read_level) < RADIUS_LEVELS) &&
            (32'(item.read_cell_x) < ACC_WIDTH) && (32'(item.read_cell_y) < ACC_HEIGHT);
  end
  always_ff @(posedge clk) begin
    if (cmd.load) cell_count <= '0;
    else if (rd_v) cell_count <= rd_ok ? s4_q : 16'd0;
  end

  assign sts.busy = s1_v | s2_v | s3_v | s4_v | rd_v;
endmodule

@@ sv/hcva_ctrl.sv @@
// Controller: sequences vote sweeps over levels and angles, cell reads
// and store clearing. Uses hcva_pkg.
module hcva_ctrl #(
  parameter int DEPTH = 65536,
  parameter int RADIUS_LEVELS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  hcva_pkg::in_beat_t in_beat,
  input  logic [2:0]         radius_count,
  input  logic [8:0]         angle_step,
  input  hcva_pkg::dp_sts_t  sts,
  output hcva_pkg::dp_cmd_t  cmd,
  output logic               done,
  input  logic               out_free
);
  localparam int CW = hcva_pkg::CLR_ADDR_W + 1;

  typedef enum logic [2:0] {S_INIT, S_IDLE, S_VOTE, S_CLEAR, S_READ, S_DRAIN, S_DONE}
    state_t;
  state_t state;
  logic [8:0]  angle;
  logic [1:0]  level;
  logic [2:0]  levels;
  logic [8:0]  step;
  logic [CW-1:0] caddr;
  logic        acc;

  assign in_ready = (state == S_IDLE);
  assign acc = in_valid && in_ready;
  assign levels = (32'(radius_count) > RADIUS_LEVELS) ? 3'(RADIUS_LEVELS) : radius_count;
  assign step = (angle_step == 9'd0) ? 9'd1 : angle_step;

  always_comb begin
    cmd = '0;
    cmd.load = acc;
    cmd.level = level;
    cmd.angle = angle;
    cmd.clr_addr = caddr[CW-2:0];
    cmd.clr_wr = (state == S_INIT || state == S_CLEAR);
    cmd.vote_go = (state == S_VOTE);
    cmd.rd_go = (state == S_READ);
  end

  // Hold state; advance angle then level
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT; caddr <= '0; angle <= '0; level <= '0; done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_INIT, S_CLEAR: begin
          caddr <= caddr + CW'(1);
          if (caddr == CW'(DEPTH - 1)) state <= (state == S_INIT) ? S_IDLE : S_DRAIN;
        end
        S_IDLE: if (acc) begin
          angle <= '0; level <= '0; caddr <= '0;
          case (in_beat.cmd)
            hcva_pkg::CMD_VOTE:
              state <= (in_beat.edge_value != 8'd0 && levels != 3'd0) ? S_VOTE : S_DRAIN;
            hcva_pkg::CMD_READ:  state <= S_READ;
            hcva_pkg::CMD_CLEAR: state <= S_CLEAR;
            default: state <= S_DRAIN;
          endcase
        end
        S_VOTE: begin
          if (10'(angle) + 10'(step) >= 10'd360) begin
            angle <= '0;
            level <= level + 2'd1;
            if (3'(level) + 3'd1 >= levels) state <= S_DRAIN;
          end else angle <= angle + step;
        end
        S_READ: state <= S_DRAIN;
        S_DRAIN: if (!sts.busy && out_free) begin
          done <= 1'b1; state <= S_DONE;
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ sv/hough_circle_vote_accumulator.sv @@
// Hough circle vote accumulator, top level. A vote item sweeps every
// configured level and angle step, one probe per cycle through the store
// read-modify-write pipe; a clear zeroes every store cell. One item at a time:
// the next beat is taken from the cycle the result shows up. After reset a
// clearing pass over all RADIUS_LEVELS*ACC_HEIGHT*ACC_WIDTH cells (sides rounded
// up to powers of two) zeroes the store; no items meanwhile.
module hough_circle_vote_accumulator #(
  parameter int ACC_WIDTH     = 128,
  parameter int ACC_HEIGHT    = 128,
  parameter int RADIUS_LEVELS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hcva_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hcva_pkg::out_beat_t out_data,
  input  logic                cfg_we,
  input  logic [hcva_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hcva_pkg::CFG_DATA_W-1:0] cfg_data
);
  localparam int STORE_DEPTH = RADIUS_LEVELS << ($clog2(ACC_HEIGHT) + $clog2(ACC_WIDTH));

  logic [7:0] radius [4];
  logic [2:0] radius_count;
  logic [8:0] angle_step;
  logic [1:0] cell_shift;
  hcva_pkg::dp_cmd_t cmd;
  hcva_pkg::dp_sts_t sts;
  logic done;
  logic [10:0] votes;
  logic [15:0] cnt;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radius[0] <= 8'd8; radius[1] <= 8'd16; radius[2] <= 8'd24; radius[3] <= 8'd32;
      radius_count <= 3'd1; angle_step <= 9'd1; cell_shift <= 2'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        hcva_pkg::REG_RADIUS_0:   radius[0] <= cfg_data[7:0];
        hcva_pkg::REG_RADIUS_1:   radius[1] <= cfg_data[7:0];
        hcva_pkg::REG_RADIUS_2:   radius[2] <= cfg_data[7:0];
        hcva_pkg::REG_RADIUS_3:   radius[3] <= cfg_data[7:0];
        hcva_pkg::REG_RADIUS_CNT: radius_count <= cfg_data[2:0];
        hcva_pkg::REG_ANGLE_STEP: angle_step <= cfg_data;
        hcva_pkg::REG_CELL_SHIFT: cell_shift <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  hcva_ctrl #(.DEPTH(STORE_DEPTH),
              .RADIUS_LEVELS(RADIUS_LEVELS)) u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .in_beat(in_data),
    .radius_count, .angle_step, .sts, .cmd, .done, .out_free(!out_valid)
  );

  hcva_datapath #(.ACC_WIDTH(ACC_WIDTH), .ACC_HEIGHT(ACC_HEIGHT),
                  .RADIUS_LEVELS(RADIUS_LEVELS)) u_dp (
    .clk, .rst, .cmd, .in_beat(in_data), .radius, .cell_shift, .sts,
    .votes, .cell_count(cnt)
  );

  // Output register: hold the result beat until taken
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (done) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (done) begin
      out_data.votes_cast <= votes;
      out_data.cell_count <= cnt;
    end
  end
endmodule
